### rtl/core/cvrw_pkg.sv
// ----------------------------------------------------------------------------
// cvrw_pkg
// Shared types, constants and the attenuation ROM of the codec volume
// register writer.
// ----------------------------------------------------------------------------
package cvrw_pkg;

	// Number of volume steps; level TABLE_STEPS and above is rejected.
	localparam int TABLE_STEPS = 31;

	localparam int LEVEL_W = 5;
	localparam int VALUE_W = 9;
	localparam int NUM_REGS = 4;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Base of the headphone and speaker codes, before attenuation.
	localparam logic signed [9:0] CODE_BASE = 10'sd121;
	localparam logic [6:0] CODE_MAX = 7'h7F;
	localparam logic [VALUE_W-1:0] SHADOW_RESET = 9'h180;

	// Configuration register indexes.
	localparam logic [1:0] REG_VOLUME_OFFSET = 2'd0;
	localparam logic [1:0] REG_OUTPUT_MUTED = 2'd1;
	localparam logic [1:0] REG_CODEC_ACTIVE = 2'd2;

	// Codec register addresses, in shadow order.
	localparam logic [6:0] CODEC_REG_ADDR [NUM_REGS] = '{7'd2, 7'd3, 7'd40, 7'd41};

	typedef enum logic [1:0] {
		STATUS_OK = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_HP_CODE = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [7:0] volume_offset;
		logic output_muted;
		logic codec_active;
	} cfg_t;

	// One evaluated request, handed from the evaluation stage to the emitter.
	typedef struct packed {
		logic [NUM_REGS-1:0] mask;
		logic [NUM_REGS-1:0][VALUE_W-1:0] vals;
		status_t status;
		logic [LEVEL_W-1:0] level;
	} item_t;

	// Attenuation ROM: headphone steps first, speaker steps after them.
	function automatic logic [6:0] atten_rom(input logic [5:0] addr);
		logic [6:0] v;
		case (addr)
			6'd0: v = 7'h7F;  6'd1: v = 7'h49;  6'd2: v = 7'h46;  6'd3: v = 7'h42;
			6'd4: v = 7'h3D;  6'd5: v = 7'h3B;  6'd6: v = 7'h39;  6'd7: v = 7'h37;
			6'd8: v = 7'h35;  6'd9: v = 7'h33;  6'd10: v = 7'h31; 6'd11: v = 7'h2F;
			6'd12: v = 7'h2D; 6'd13: v = 7'h2B; 6'd14: v = 7'h29; 6'd15: v = 7'h27;
			6'd16: v = 7'h25; 6'd17: v = 7'h23; 6'd18: v = 7'h21; 6'd19: v = 7'h1F;
			6'd20: v = 7'h1D; 6'd21: v = 7'h1B; 6'd22: v = 7'h19; 6'd23: v = 7'h17;
			6'd24: v = 7'h15; 6'd25: v = 7'h13; 6'd26: v = 7'h11; 6'd27: v = 7'h0F;
			6'd28: v = 7'h0D; 6'd29: v = 7'h0B; 6'd30: v = 7'h09; 6'd31: v = 7'h7F;
			6'd32: v = 7'h1E; 6'd33: v = 7'h1D; 6'd34: v = 7'h1C; 6'd35: v = 7'h1B;
			6'd36: v = 7'h1A; 6'd37: v = 7'h19; 6'd38: v = 7'h18; 6'd39: v = 7'h17;
			6'd40: v = 7'h16; 6'd41: v = 7'h15; 6'd42: v = 7'h14; 6'd43: v = 7'h13;
			6'd44: v = 7'h12; 6'd45: v = 7'h11; 6'd46: v = 7'h10; 6'd47: v = 7'h0F;
			6'd48: v = 7'h0E; 6'd49: v = 7'h0D; 6'd50: v = 7'h0C; 6'd51: v = 7'h0B;
			6'd52: v = 7'h0A; 6'd53: v = 7'h09; 6'd54: v = 7'h08; 6'd55: v = 7'h07;
			6'd56: v = 7'h06; 6'd57: v = 7'h05; 6'd58: v = 7'h04; 6'd59: v = 7'h03;
			6'd60: v = 7'h02; 6'd61: v = 7'h01;
			default: v = 7'h00;
		endcase
		return v;
	endfunction

endpackage

### rtl/core/cvrw_regs.sv
// ----------------------------------------------------------------------------
// cvrw_regs
// APB-style configuration registers: volume offset, mute and codec active.
// ----------------------------------------------------------------------------
module cvrw_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cvrw_pkg::ADDR_W-1:0]   paddr,
	input  logic [cvrw_pkg::DATA_W-1:0]   pwdata,
	output logic [cvrw_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output cvrw_pkg::cfg_t                cfg
);

	cvrw_pkg::cfg_t cfg_q;
	logic [1:0] reg_idx;
	logic wr_en;

	assign pready = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en = psel && penable && pwrite && pready;
	assign cfg = cfg_q;

	// Register writes complete in the access phase of the transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.volume_offset <= 8'sd0;
			cfg_q.output_muted <= 1'b0;
			cfg_q.codec_active <= 1'b1;
		end else if (wr_en) begin
			case (reg_idx)
				cvrw_pkg::REG_VOLUME_OFFSET: cfg_q.volume_offset <= $signed(pwdata[7:0]);
				cvrw_pkg::REG_OUTPUT_MUTED: cfg_q.output_muted <= pwdata[0];
				cvrw_pkg::REG_CODEC_ACTIVE: cfg_q.codec_active <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// Read data mux.
	always_comb begin
		case (reg_idx)
			cvrw_pkg::REG_VOLUME_OFFSET: prdata = {24'd0, cfg_q.volume_offset};
			cvrw_pkg::REG_OUTPUT_MUTED: prdata = {31'd0, cfg_q.output_muted};
			cvrw_pkg::REG_CODEC_ACTIVE: prdata = {31'd0, cfg_q.codec_active};
			default: prdata = '0;
		endcase
	end

endmodule

### rtl/core/cvrw_eval.sv
// ----------------------------------------------------------------------------
// cvrw_eval
// Input register, code computation and the codec register shadows. A held
// request is evaluated in the cycle it is handed to the emitter.
// ----------------------------------------------------------------------------
module cvrw_eval (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cvrw_pkg::cfg_t                 cfg,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [cvrw_pkg::LEVEL_W-1:0]   volume_level,
	output logic                           item_valid,
	input  logic                           item_ready,
	output cvrw_pkg::item_t                item
);

	logic valid_s1;
	logic [cvrw_pkg::LEVEL_W-1:0] level_s1;
	logic [cvrw_pkg::VALUE_W-1:0] shadow_q [cvrw_pkg::NUM_REGS];
	logic [cvrw_pkg::LEVEL_W-1:0] stored_level_q;

	logic load;
	logic range_err;
	logic hp_err;
	logic [cvrw_pkg::LEVEL_W-1:0] idx;
	logic [5:0] sp_addr;
	logic signed [9:0] off_ext;
	logic signed [9:0] hp_raw;
	logic signed [9:0] sp_raw;
	logic [6:0] hp_code;
	logic [6:0] sp_code;
	logic [cvrw_pkg::NUM_REGS-1:0][cvrw_pkg::VALUE_W-1:0] vals;
	logic [cvrw_pkg::NUM_REGS-1:0] mask;
	logic ok;

	assign load = valid_s1 && item_ready;
	assign in_ready = !valid_s1 || load;
	assign item_valid = valid_s1;

	// Input register for one request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			level_s1 <= volume_level;
		end
	end

	// Headphone and speaker codes from the ROM and the offset.
	always_comb begin
		range_err = {2'b00, level_s1} >= 7'(cvrw_pkg::TABLE_STEPS);
		idx = cfg.output_muted ? '0 : level_s1;
		sp_addr = 6'({1'b0, idx} + 6'(cvrw_pkg::TABLE_STEPS));
		off_ext = {{2{cfg.volume_offset[7]}}, cfg.volume_offset};
		hp_raw = cvrw_pkg::CODE_BASE - $signed({3'b000, cvrw_pkg::atten_rom({1'b0, idx})})
			+ off_ext;
		sp_raw = cvrw_pkg::CODE_BASE - $signed({3'b000, cvrw_pkg::atten_rom(sp_addr)})
			+ off_ext;
		// A headphone code of 128 or more is an error; a negative one becomes zero.
		hp_err = !hp_raw[9] && (hp_raw[8:7] != 2'b00);
		hp_code = hp_raw[9] ? 7'd0 : hp_raw[6:0];
		// The speaker code is clamped to the 7-bit range.
		if (sp_raw[9]) begin
			sp_code = 7'd0;
		end else if (sp_raw[8:7] != 2'b00) begin
			sp_code = cvrw_pkg::CODE_MAX;
		end else begin
			sp_code = sp_raw[6:0];
		end
		vals[0] = {2'b01, hp_code};
		vals[1] = {2'b11, hp_code};
		vals[2] = {2'b01, sp_code};
		vals[3] = {2'b11, sp_code};
		ok = !range_err && !hp_err;
		for (int i = 0; i < cvrw_pkg::NUM_REGS; i++) begin
			mask[i] = ok && cfg.codec_active && (vals[i] != shadow_q[i]);
		end
	end

	// Evaluated request for the emitter.
	always_comb begin
		item.mask = mask;
		item.vals = vals;
		if (range_err) begin
			item.status = cvrw_pkg::STATUS_RANGE;
		end else if (hp_err) begin
			item.status = cvrw_pkg::STATUS_HP_CODE;
		end else begin
			item.status = cvrw_pkg::STATUS_OK;
		end
		item.level = ok ? level_s1 : stored_level_q;
	end

	// Shadows follow every frame sent; the stored level follows every good request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cvrw_pkg::NUM_REGS; i++) begin
				shadow_q[i] <= cvrw_pkg::SHADOW_RESET;
			end
			stored_level_q <= '0;
		end else if (load) begin
			for (int i = 0; i < cvrw_pkg::NUM_REGS; i++) begin
				if (mask[i]) begin
					shadow_q[i] <= vals[i];
				end
			end
			if (ok) begin
				stored_level_q <= level_s1;
			end
		end
	end

endmodule

### rtl/core/cvrw_emit.sv
// ----------------------------------------------------------------------------
// cvrw_emit
// Result register: sends the changed register frames of one request, one
// transfer per unstalled cycle, or a single empty result when nothing is sent.
// ----------------------------------------------------------------------------
module cvrw_emit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  cvrw_pkg::item_t                item,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           write_valid,
	output logic [7:0]                     frame_first_byte,
	output logic [7:0]                     frame_second_byte,
	output logic [1:0]                     status,
	output logic                           last,
	output logic [cvrw_pkg::LEVEL_W-1:0]   current_level
);

	logic busy_q;
	logic [cvrw_pkg::NUM_REGS-1:0] mask_q;
	cvrw_pkg::item_t item_q;
	logic [1:0] sel;
	logic [cvrw_pkg::VALUE_W-1:0] sel_val;
	logic done;

	// Lowest pending register goes out first.
	always_comb begin
		sel = 2'd0;
		for (int i = cvrw_pkg::NUM_REGS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel = 2'(i);
			end
		end
		sel_val = item_q.vals[sel];
	end

	assign last = (mask_q & (mask_q - 4'd1)) == '0;
	assign done = out_ready && last;
	assign item_ready = !busy_q || done;

	assign out_valid = busy_q;
	assign write_valid = |mask_q;
	assign frame_first_byte = write_valid ? {cvrw_pkg::CODEC_REG_ADDR[sel], sel_val[8]} : 8'd0;
	assign frame_second_byte = write_valid ? sel_val[7:0] : 8'd0;
	assign status = item_q.status;
	assign current_level = item_q.level;

	// Control: load a new request, or drop the frame just transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mask_q <= '0;
		end else if (item_ready) begin
			busy_q <= item_valid;
			mask_q <= item_valid ? item.mask : '0;
		end else if (out_ready) begin
			mask_q <= mask_q & (mask_q - 4'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_q <= item;
		end
	end

endmodule

### rtl/core/codec_volume_register_writer.sv
// ----------------------------------------------------------------------------
// codec_volume_register_writer
// Turns a volume level request into codec register frames for an I2C master.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, volume_level) carries one level
// request per transfer. The output channel (out_valid, out_ready) carries one
// to four results per request: one per changed codec register (registers 2,
// 3, 40, 41 in that order), or a single result with write_valid low. The last
// result of a request has last high. The APB-style port sets the offset, the
// mute and the codec active bit; write it only while the block is idle.
// A request passes through the input register and then the result register
// before its first result is offered.
// Throughput: one result per cycle while the receiver is ready; a request
// occupies the result register until its last result transfers, so up to one
// request per cycle is taken when each gives a single result.
// While the receiver stalls, the current result holds and one more request
// waits in the input register. Reset clears the pipeline, sets all register
// shadows to 0x180, the stored level to 0, and the codec active bit to 1.
// ----------------------------------------------------------------------------
module codec_volume_register_writer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cvrw_pkg::ADDR_W-1:0]   paddr,
	input  logic [cvrw_pkg::DATA_W-1:0]   pwdata,
	output logic [cvrw_pkg::DATA_W-1:0]   prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [cvrw_pkg::LEVEL_W-1:0]   volume_level,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           write_valid,
	output logic [7:0]                     frame_first_byte,
	output logic [7:0]                     frame_second_byte,
	output logic [1:0]                     status,
	output logic                           last,
	output logic [cvrw_pkg::LEVEL_W-1:0]   current_level
);

	cvrw_pkg::cfg_t cfg;
	cvrw_pkg::item_t item;
	logic item_valid;
	logic item_ready;

	cvrw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cvrw_eval u_eval (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.volume_level (volume_level),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item)
	);

	cvrw_emit u_emit (
		.clk               (clk),
		.arst_n            (arst_n),
		.item_valid        (item_valid),
		.item_ready        (item_ready),
		.item              (item),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.write_valid       (write_valid),
		.frame_first_byte  (frame_first_byte),
		.frame_second_byte (frame_second_byte),
		.status            (status),
		.last              (last),
		.current_level     (current_level)
	);

endmodule

### rtl/core/cvrw_checker.sv
// ----------------------------------------------------------------------------
// cvrw_checker
// Port-level checks on the result channel of the volume register writer.
// ----------------------------------------------------------------------------
module cvrw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       write_valid,
	input logic [7:0] frame_first_byte,
	input logic [7:0] frame_second_byte,
	input logic [1:0] status,
	input logic       last
);

	// A stalled result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A frame only goes out for a good request.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_valid |-> status == cvrw_pkg::STATUS_OK)
		else $error("frame sent with error status");

	// An empty result is always the only one of its request and carries zero bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_valid |->
		last && frame_first_byte == 8'd0 && frame_second_byte == 8'd0)
		else $error("malformed empty result");

	// Frames only address the four volume registers, left with bit 8 clear, right set.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_valid |->
		frame_first_byte == 8'd4 || frame_first_byte == 8'd7 ||
		frame_first_byte == 8'd80 || frame_first_byte == 8'd83)
		else $error("frame for an unexpected register");

	// Every frame value has bit 7 set.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_valid |-> frame_second_byte[7])
		else $error("frame value missing update bit");

endmodule

bind codec_volume_register_writer cvrw_checker u_cvrw_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_valid),
	.out_ready         (out_ready),
	.write_valid       (write_valid),
	.frame_first_byte  (frame_first_byte),
	.frame_second_byte (frame_second_byte),
	.status            (status),
	.last              (last)
);
